// File: design/casr_pkg.sv
// ----------------------------------------------------------------------------
// casr_pkg: shared types and constants for the connection attempt racer
// Holds the request and response transaction structs, opcode, status and
// attempt state codes, and the command struct from controller to datapath.
// ----------------------------------------------------------------------------
package casr_pkg;

  // table geometry, fixed by the slot field widths
  localparam int unsigned MaxSlots = 8;
  localparam int unsigned SlotW    = 3;
  localparam int unsigned CountW   = 4;
  localparam int unsigned DelayW   = 16;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned ProdW    = SlotW + DelayW;

  localparam logic [DelayW-1:0] DefaultDelay = 16'd250;

  // opcodes
  localparam logic [2:0] OpClear   = 3'd0;
  localparam logic [2:0] OpAdd     = 3'd1;
  localparam logic [2:0] OpPoll    = 3'd2;
  localparam logic [2:0] OpConnect = 3'd3;
  localparam logic [2:0] OpFail    = 3'd4;

  // response status codes
  localparam logic [1:0] StsDone   = 2'd0;
  localparam logic [1:0] StsCancel = 2'd1;
  localparam logic [1:0] StsReject = 2'd2;

  // per-slot attempt state codes
  localparam logic [1:0] AtPending   = 2'd0;
  localparam logic [1:0] AtConnected = 2'd1;
  localparam logic [1:0] AtFailed    = 2'd2;

  // request transaction
  typedef struct packed {
    logic [2:0]       opcode;
    logic [TimeW-1:0] now_time;
    logic [SlotW-1:0] slot_index;
  } casr_req_t;

  // response transaction
  typedef struct packed {
    logic [1:0]        status;
    logic [SlotW-1:0]  result_slot;
    logic              winner_valid;
    logic [SlotW-1:0]  winner_slot;
    logic              every_failed;
    logic [CountW-1:0] slot_count;
  } casr_rsp_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic execute;
  } casr_cmd_t;

endpackage

// File: design/connect_attempt_stagger_racer.sv
// ----------------------------------------------------------------------------
// connect_attempt_stagger_racer: staggered connection attempt racer
// Tracks up to eight attempt slots, starts them at staggered times on poll,
// picks the first connected slot as winner and reports table status.
// ----------------------------------------------------------------------------
//  channel   | handshake                 | payload
//  ----------+---------------------------+------------------------------
//  request   | start / busy              | req_i  (opcode, now_time, slot)
//  response  | done_o strobe, no stall   | rsp_o  (status, slots, flags)
//  config    | cfg_valid_i / cfg_ready_o | cfg_data_i (stagger delay)
//
//  each transaction runs through a capture step (slot scan and stagger
//  multiply) then an execute step (elapsed compare and table update)
//  busy is high in the execute cycle; a new start is taken the next cycle
//  the response appears in the cycle after execute, for one cycle on done_o
//  the receiver cannot stall; no new start is taken while busy
//  reset clears the slot table and loads the stagger delay with 250
// ----------------------------------------------------------------------------
module connect_attempt_stagger_racer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  casr_pkg::casr_req_t         req_i,
  output logic                        done_o,
  output casr_pkg::casr_rsp_t         rsp_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [casr_pkg::DelayW-1:0] cfg_data_i
);
  import casr_pkg::*;

  casr_cmd_t cmd;

  // sequencer
  casr_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd)
  );

  // slot table and decisions
  casr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .req_i       (req_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .rsp_o       (rsp_o)
  );

endmodule

// File: design/casr_ctrl.sv
// ----------------------------------------------------------------------------
// casr_ctrl: command sequencer for the connection attempt racer
// Two-state machine: idle waits for start, exec lets the datapath apply the
// captured transaction; the response strobe follows in the cycle after exec.
// ----------------------------------------------------------------------------
module casr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  output logic                done_o,
  output casr_pkg::casr_cmd_t cmd_o
);
  import casr_pkg::*;

  localparam logic StIdle = 1'b0;
  localparam logic StExec = 1'b1;

  logic state_q, state_d;
  logic done_q, done_d;
  logic accept;

  // handshake
  assign accept = start && (state_q == StIdle);
  assign busy   = (state_q == StExec);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StExec;
        end
      end
      StExec: begin
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  assign done_d = (state_q == StExec);

  // state and strobe registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  // datapath commands
  assign cmd_o.capture = accept;
  assign cmd_o.execute = (state_q == StExec);
  assign done_o        = done_q;

`ifndef NO_ASSERTIONS
  // an accepted transaction always yields a response strobe after its exec state
  a_accept_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##2 done_o) else $error("missing response strobe");

  // no strobe overlaps an executing transaction
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("strobe while busy");
`endif

endmodule

// File: design/casr_dp.sv
// ----------------------------------------------------------------------------
// casr_dp: slot table and decision logic for the connection attempt racer
// Capture cycle registers the request, the lowest unstarted slot and its
// stagger offset; execute cycle checks elapsed time, updates the table and
// registers the response.
// ----------------------------------------------------------------------------
module casr_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  casr_pkg::casr_cmd_t         cmd_i,
  input  casr_pkg::casr_req_t         req_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [casr_pkg::DelayW-1:0] cfg_data_i,
  output casr_pkg::casr_rsp_t         rsp_o
);
  import casr_pkg::*;

  // architectural state
  logic [CountW-1:0]   count_q, count_d;
  logic [MaxSlots-1:0] started_q, started_d;
  logic [1:0]          att_q [MaxSlots];
  logic [1:0]          att_d [MaxSlots];
  logic [TimeW-1:0]    first_q, first_d;
  logic                any_q, any_d;
  logic                winv_q, winv_d;
  logic [SlotW-1:0]    win_q, win_d;
  logic [DelayW-1:0]   delay_q;

  // captured transaction
  logic [2:0]          op_q;
  logic [TimeW-1:0]    now_q;
  logic [SlotW-1:0]    idx_q;
  logic                hit_q, hit_d;
  logic [SlotW-1:0]    scan_q, scan_d;
  logic [ProdW-1:0]    prod_q, prod_d;
  casr_rsp_t           rsp_q, rsp_d;

  logic [DelayW-1:0]   delay_eff;
  logic [TimeW-1:0]    elapsed;
  logic                due;
  logic                slot_ok;
  logic                all_failed;

  // config register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= DefaultDelay;
    end else if (cfg_valid_i && cfg_ready_o) begin
      delay_q <= cfg_data_i;
    end
  end

  // lowest unstarted slot below count
  always_comb begin
    hit_d  = 1'b0;
    scan_d = '0;
    for (int i = MaxSlots - 1; i >= 0; i--) begin
      if ((CountW'(i) < count_q) && !started_q[i]) begin
        hit_d  = 1'b1;
        scan_d = SlotW'(i);
      end
    end
  end

  // stagger offset for that slot, zero delay acts as default
  assign delay_eff = (delay_q == '0) ? DefaultDelay : delay_q;
  assign prod_d    = ProdW'(scan_d) * ProdW'(delay_eff);

  // capture registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= req_i.opcode;
      now_q  <= req_i.now_time;
      idx_q  <= req_i.slot_index;
      hit_q  <= hit_d;
      scan_q <= scan_d;
      prod_q <= prod_d;
    end
  end

  // execute decisions
  assign elapsed = now_q - first_q;
  assign due     = !any_q || (elapsed >= TimeW'(prod_q));
  assign slot_ok = (CountW'(idx_q) < count_q);

  always_comb begin
    count_d   = count_q;
    started_d = started_q;
    att_d     = att_q;
    first_d   = first_q;
    any_d     = any_q;
    winv_d    = winv_q;
    win_d     = win_q;
    rsp_d.status      = StsReject;
    rsp_d.result_slot = '0;
    unique case (op_q)
      OpClear: begin
        count_d   = '0;
        started_d = '0;
        for (int i = 0; i < MaxSlots; i++) begin
          att_d[i] = AtPending;
        end
        first_d = '0;
        any_d   = 1'b0;
        winv_d  = 1'b0;
        win_d   = '0;
        rsp_d.status = StsDone;
      end
      OpAdd: begin
        if (count_q < CountW'(MaxSlots)) begin
          started_d[count_q[SlotW-1:0]] = 1'b0;
          att_d[count_q[SlotW-1:0]]     = AtPending;
          rsp_d.result_slot = count_q[SlotW-1:0];
          count_d           = count_q + CountW'(1);
          rsp_d.status      = StsDone;
        end
      end
      OpPoll: begin
        if (hit_q && due) begin
          started_d[scan_q] = 1'b1;
          if (!any_q) begin
            any_d   = 1'b1;
            first_d = now_q;
          end
          rsp_d.result_slot = scan_q;
          rsp_d.status      = StsDone;
        end
      end
      OpConnect: begin
        if (slot_ok) begin
          if (!winv_q) begin
            winv_d       = 1'b1;
            win_d        = idx_q;
            att_d[idx_q] = AtConnected;
            rsp_d.status = StsDone;
          end else begin
            rsp_d.status = StsCancel;
          end
        end
      end
      OpFail: begin
        if (slot_ok) begin
          att_d[idx_q] = AtFailed;
          rsp_d.status = StsDone;
        end
      end
      default: ;
    endcase

    // every added slot failed, taken after the update
    all_failed = (count_d != '0);
    for (int i = 0; i < MaxSlots; i++) begin
      if ((CountW'(i) < count_d) && (att_d[i] != AtFailed)) begin
        all_failed = 1'b0;
      end
    end

    rsp_d.winner_valid = winv_d;
    rsp_d.winner_slot  = win_d;
    rsp_d.every_failed = all_failed;
    rsp_d.slot_count   = count_d;
  end

  // slot table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      started_q <= '0;
      for (int i = 0; i < MaxSlots; i++) begin
        att_q[i] <= AtPending;
      end
      first_q <= '0;
      any_q   <= 1'b0;
      winv_q  <= 1'b0;
      win_q   <= '0;
    end else if (cmd_i.execute) begin
      count_q   <= count_d;
      started_q <= started_d;
      att_q     <= att_d;
      first_q   <= first_d;
      any_q     <= any_d;
      winv_q    <= winv_d;
      win_q     <= win_d;
    end
  end

  // response register
  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o = rsp_q;

`ifndef NO_ASSERTIONS
  // table never grows past its capacity
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(MaxSlots)) else $error("slot count overflow");

  // a winner always names an added slot
  a_winner_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    winv_q |-> (CountW'(win_q) < count_q)) else $error("winner out of range");

  // started flags only exist once the first start time is recorded
  a_started_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !any_q |-> (started_q == '0)) else $error("slot started without first time");
`endif

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for connect_attempt_stagger_racer
// Drives request transactions over start/busy and stagger delay writes over
// the config channel, keeps its own model of the slot table and compares
// every response strobe field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  import casr_pkg::*;

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  logic      busy;
  casr_req_t req_i;
  logic      done_o;
  casr_rsp_t rsp_o;
  logic      cfg_valid_i;
  logic      cfg_ready_o;
  logic [DelayW-1:0] cfg_data_i;

  connect_attempt_stagger_racer uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .done_o      (done_o),
    .rsp_o       (rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // racer model state
  int unsigned       tbl_count;
  logic              tbl_started [MaxSlots];
  logic [1:0]        tbl_state   [MaxSlots];
  logic [TimeW-1:0]  tbl_first;
  logic              tbl_any;
  logic              tbl_has_win;
  logic [SlotW-1:0]  tbl_winner;
  logic [DelayW-1:0] tbl_delay;

  casr_rsp_t   pending_rsp[$];
  int unsigned fail_count;
  int unsigned phase_items;
  bit          gaps_on;

  // clock and timeout
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [TimeW-1:0] stagger_step();
    return (tbl_delay == '0) ? TimeW'(DefaultDelay) : TimeW'(tbl_delay);
  endfunction

  function automatic void clear_table();
    tbl_count   = 0;
    tbl_first   = '0;
    tbl_any     = 1'b0;
    tbl_has_win = 1'b0;
    tbl_winner  = '0;
    for (int i = 0; i < MaxSlots; i++) begin
      tbl_started[i] = 1'b0;
      tbl_state[i]   = AtPending;
    end
  endfunction

  // apply one request to the model and build the response it causes
  function automatic casr_rsp_t race_step(casr_req_t rq);
    casr_rsp_t        r;
    logic [TimeW-1:0] due;
    logic             all_fail;
    r = '0;
    r.status = StsReject;
    case (rq.opcode)
      OpClear: begin
        clear_table();
        r.status = StsDone;
      end
      OpAdd: begin
        if (tbl_count < MaxSlots) begin
          tbl_started[tbl_count] = 1'b0;
          tbl_state[tbl_count]   = AtPending;
          r.result_slot = SlotW'(tbl_count);
          tbl_count++;
          r.status = StsDone;
        end
      end
      OpPoll: begin
        for (int i = 0; i < tbl_count; i++) begin
          if (!tbl_started[i]) begin
            due = TimeW'(i) * stagger_step();
            if (!tbl_any || (rq.now_time - tbl_first) >= due) begin
              tbl_started[i] = 1'b1;
              if (!tbl_any) begin
                tbl_any   = 1'b1;
                tbl_first = rq.now_time;
              end
              r.result_slot = SlotW'(i);
              r.status = StsDone;
            end
            break;
          end
        end
      end
      OpConnect: begin
        if (rq.slot_index < tbl_count) begin
          if (!tbl_has_win) begin
            tbl_has_win = 1'b1;
            tbl_winner  = rq.slot_index;
            tbl_state[rq.slot_index] = AtConnected;
            r.status = StsDone;
          end else begin
            r.status = StsCancel;
          end
        end
      end
      OpFail: begin
        if (rq.slot_index < tbl_count) begin
          tbl_state[rq.slot_index] = AtFailed;
          r.status = StsDone;
        end
      end
      default: ;
    endcase
    all_fail = (tbl_count != 0);
    for (int i = 0; i < tbl_count; i++)
      if (tbl_state[i] != AtFailed) all_fail = 1'b0;
    r.winner_valid = tbl_has_win;
    r.winner_slot  = tbl_has_win ? tbl_winner : '0;
    r.every_failed = all_fail;
    r.slot_count   = CountW'(tbl_count);
    return r;
  endfunction

  // send one request transaction, with an optional idle gap first
  task automatic send_req(logic [2:0] op, logic [TimeW-1:0] t, logic [SlotW-1:0] idx);
    int unsigned gap;
    gap = 0;
    if (gaps_on && $urandom_range(0, 99) < 20) gap = $urandom_range(1, 4);
    repeat (gap) begin
      @(negedge clk_i);
      start = 1'b0;
    end
    @(negedge clk_i);
    start            = 1'b1;
    req_i.opcode     = op;
    req_i.now_time   = t;
    req_i.slot_index = idx;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    pending_rsp.push_back(race_step(req_i));
    phase_items++;
  endtask

  // wait until every response is in, then let the block settle
  task automatic drain();
    int unsigned n;
    n = 0;
    @(negedge clk_i);
    start = 1'b0;
    while (pending_rsp.size() != 0 && n < 1000) begin
      @(posedge clk_i);
      n++;
    end
    if (pending_rsp.size() != 0) begin
      fail_count++;
      $display("%0t: response count mismatch, expected %0d more actual 0", $time,
               pending_rsp.size());
      pending_rsp.delete();
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_delay(logic [DelayW-1:0] v);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = v;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    tbl_delay = v;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  // response checker
  always @(posedge clk_i) begin
    casr_rsp_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (pending_rsp.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected response, expected none actual %h", $time, rsp_o);
      end else begin
        want = pending_rsp.pop_front();
        check_field("status",       32'(want.status),       32'(rsp_o.status));
        check_field("result_slot",  32'(want.result_slot),  32'(rsp_o.result_slot));
        check_field("winner_valid", 32'(want.winner_valid), 32'(rsp_o.winner_valid));
        check_field("winner_slot",  32'(want.winner_slot),  32'(rsp_o.winner_slot));
        check_field("every_failed", 32'(want.every_failed), 32'(rsp_o.every_failed));
        check_field("slot_count",   32'(want.slot_count),   32'(rsp_o.slot_count));
      end
    end
  end

  // full table and unknown opcodes
  task automatic test_table_limits();
    send_req(OpClear, '0, '0);
    for (int i = 0; i <= MaxSlots; i++) send_req(OpAdd, '1, SlotW'(i));
    send_req(3'd5, 32'hFFFF_FFFF, 3'd7);
    send_req(3'd6, 32'h0, 3'd0);
    send_req(3'd7, 32'hA5A5_5A5A, 3'd5);
  endtask

  // first start at once, nothing due, start across time wrap
  task automatic test_stagger_wrap();
    send_req(OpPoll, 32'hFFFF_FF00, 3'd7);
    send_req(OpPoll, 32'hFFFF_FF00 + 32'd249, 3'd0);
    send_req(OpPoll, 32'hFFFF_FF00 + 32'd500, 3'd0);
  endtask

  // out of range slot, winner, late connect, failed winner, every failed
  task automatic test_race_outcome();
    send_req(OpClear, '0, '0);
    repeat (3) send_req(OpAdd, '0, '0);
    send_req(OpConnect, '0, 3'd5);
    send_req(OpConnect, '0, 3'd1);
    send_req(OpConnect, '0, 3'd0);
    send_req(OpFail, '0, 3'd1);
    send_req(OpFail, '0, 3'd0);
    send_req(OpFail, '0, 3'd2);
  endtask

  // poll time near the next due boundary, or anywhere
  function automatic logic [TimeW-1:0] pick_poll_time();
    logic [TimeW-1:0] step;
    int unsigned      k;
    if (!tbl_any || $urandom_range(0, 9) == 0) return $urandom;
    step = stagger_step();
    k = 0;
    for (int i = tbl_count - 1; i >= 0; i--)
      if (!tbl_started[i]) k = i;
    case ($urandom_range(0, 3))
      0: return tbl_first + TimeW'(k) * step - 1;
      1: return tbl_first + TimeW'(k) * step;
      2: return tbl_first + TimeW'(k) * step + $urandom_range(0, 3);
      default: return tbl_first + TimeW'(k) * step - $urandom_range(0, step);
    endcase
  endfunction

  // one race: usually a clear, add slots, then polls, connection events and random opcodes
  task automatic run_race();
    int unsigned n_slots;
    int unsigned n_events;
    logic [SlotW-1:0] idx;
    if ($urandom_range(0, 5) != 0) send_req(OpClear, $urandom, SlotW'($urandom));
    n_slots = $urandom_range(1, MaxSlots);
    repeat (n_slots) send_req(OpAdd, $urandom, SlotW'($urandom));
    if ($urandom_range(0, 7) == 0) send_req(OpAdd, $urandom, SlotW'($urandom));
    n_events = 3 * n_slots + $urandom_range(2, 6);
    repeat (n_events) begin
      if (tbl_count != 0 && $urandom_range(0, 4) != 0)
        idx = SlotW'($urandom_range(0, tbl_count - 1));
      else
        idx = SlotW'($urandom);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: send_req(OpPoll, pick_poll_time(), SlotW'($urandom));
        5, 6:          send_req(OpConnect, $urandom, idx);
        7, 8:          send_req(OpFail, $urandom, idx);
        default:       send_req(3'($urandom), $urandom, SlotW'($urandom));
      endcase
    end
  endtask

  // random races under several stagger delays
  task automatic test_random_races();
    logic [DelayW-1:0] delays [5];
    delays[0] = 16'd1;
    delays[1] = 16'hFFFF;
    delays[2] = 16'd0;
    delays[3] = DelayW'($urandom_range(1, 16'hFFFF));
    delays[4] = DefaultDelay;
    for (int p = 0; p < 5; p++) begin
      drain();
      write_delay(delays[p]);
      gaps_on     = (p != 3);
      phase_items = 0;
      while (phase_items < 265) run_race();
    end
    gaps_on = 1'b1;
  endtask

  // main sequence
  initial begin
    rst_ni      = 1'b0;
    start       = 1'b0;
    req_i       = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    fail_count  = 0;
    phase_items = 0;
    gaps_on     = 1'b1;
    tbl_delay   = DefaultDelay;
    clear_table();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(posedge clk_i);

    test_table_limits();
    test_stagger_wrap();
    test_race_outcome();
    test_random_races();

    drain();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
design/casr_pkg.sv
design/casr_ctrl.sv
design/casr_dp.sv
design/connect_attempt_stagger_racer.sv
sim/testbench.sv
